/* hdl/assert_macros.svh */
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Check an implication in the next cycle.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

/* hdl/w2s_pkg.sv */
// Shared types, constants and helpers for the vertex projection unit.
package w2s_pkg;
   localparam int FRAC_BITS = 16;
   localparam int ONE_Q = 1 << FRAC_BITS;
   localparam int DEPTH_MIN = (ONE_Q + 500) / 1000;
   localparam int DIV_STEPS = 32 + FRAC_BITS + 1;
   localparam logic [13:0] WIDTH_RESET  = 14'd1080;
   localparam logic [13:0] HEIGHT_RESET = 14'd2400;
   localparam logic [0:0] ADDR_WIDTH  = 1'b0;
   localparam logic [0:0] ADDR_HEIGHT = 1'b1;
   localparam logic KIND_LOAD = 1'b0;
   localparam logic SEL_VIEW  = 1'b0;

   typedef struct packed {
      logic               kind;
      logic               matrix_select;
      logic [3:0]         element_index;
      logic signed [31:0] element_value;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } req_type;

   typedef struct packed {
      logic               visible;
      logic signed [31:0] screen_x;
      logic signed [31:0] screen_y;
   } rsp_type;

   typedef logic signed [31:0] mat_type [16];

   // Saturate a wide signed value to 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
      logic signed [95:0] hi;
      logic signed [95:0] lo;
      hi = 96'sh7FFFFFFF;
      lo = -96'sh80000000;
      if (v > hi) sat32 = 32'sh7FFFFFFF;
      else if (v < lo) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
   endfunction
endpackage

/* hdl/w2s_divider.sv */
// Pipelined restoring divider: one quotient bit per stage, truncating toward zero.
module w2s_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  logic signed [31:0] in_num,
   input  logic signed [31:0] in_den,
   input  logic [2:0]         in_tag,
   output logic               out_valid,
   output logic signed [31:0] out_quot,
   output logic [2:0]         out_tag
);
   localparam int N = w2s_pkg::DIV_STEPS;
   localparam int QW = 32 + w2s_pkg::FRAC_BITS;

   logic            v_ff [N+1];
   logic [QW-1:0]   rem_ff [N+1];
   logic [QW-1:0]   quo_ff [N+1];
   logic [31:0]     den_ff [N+1];
   logic            neg_ff [N+1];
   logic [2:0]      tag_ff [N+1];

   logic [31:0] anum;
   logic [31:0] aden;
   assign anum = in_num[31] ? 32'(-in_num) : in_num;
   assign aden = in_den[31] ? 32'(-in_den) : in_den;

   // Load the first stage with magnitudes, numerator pre-scaled by one.
   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else if (advance) v_ff[0] <= in_valid;
      if (advance) begin
         quo_ff[0] <= {anum, {w2s_pkg::FRAC_BITS{1'b0}}};
         rem_ff[0] <= '0;
         den_ff[0] <= aden;
         neg_ff[0] <= in_num[31] ^ in_den[31];
         tag_ff[0] <= in_tag;
      end
   end

   // A quotient bit per stage, last one holds; remainder shifts in dividend bits.
   genvar s;
   generate
      for (s = 0; s < N; s++) begin : g_step
         logic [QW:0] trial;
         logic [QW:0] diff;
         assign trial = (s == N - 1) ? {1'b0, rem_ff[s]}
                        : {rem_ff[s], quo_ff[s][QW-1]};
         assign diff = trial - {{(QW-31){1'b0}}, den_ff[s]};
         always_ff @(posedge clock) begin
            if (reset) v_ff[s+1] <= 1'b0;
            else if (advance) v_ff[s+1] <= v_ff[s];
            if (advance) begin
               den_ff[s+1] <= den_ff[s];
               neg_ff[s+1] <= neg_ff[s];
               tag_ff[s+1] <= tag_ff[s];
               if (s == N - 1) begin
                  rem_ff[s+1] <= rem_ff[s];
                  quo_ff[s+1] <= quo_ff[s];
               end else if (!diff[QW]) begin
                  rem_ff[s+1] <= diff[QW-1:0];
                  quo_ff[s+1] <= {quo_ff[s][QW-2:0], 1'b1};
               end else begin
                  rem_ff[s+1] <= trial[QW-1:0];
                  quo_ff[s+1] <= {quo_ff[s][QW-2:0], 1'b0};
               end
            end
         end
      end
   endgenerate

   logic signed [QW+1:0] sq;
   assign sq = neg_ff[N] ? -$signed({2'b00, quo_ff[N]}) : $signed({2'b00, quo_ff[N]});
   assign out_valid = v_ff[N];
   assign out_quot  = w2s_pkg::sat32(96'(sq));
   assign out_tag   = tag_ff[N];
endmodule

/* hdl/w2s_transform.sv */
// Matrix store and the two fixed-point matrix-vector stages.
module w2s_transform (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  w2s_pkg::req_type   in_req,
   output logic               out_valid,
   output logic signed [31:0] out_p [3],
   output logic signed [31:0] out_w
);
   localparam int F = w2s_pkg::FRAC_BITS;

   w2s_pkg::mat_type view_ff;
   w2s_pkg::mat_type proj_ff;

   logic view_load;
   logic proj_load;
   assign view_load = in_valid && in_req.kind == w2s_pkg::KIND_LOAD
                      && in_req.matrix_select == w2s_pkg::SEL_VIEW;
   assign proj_load = in_valid && in_req.kind == w2s_pkg::KIND_LOAD
                      && in_req.matrix_select != w2s_pkg::SEL_VIEW;

   // Projection loads travel two stages so they land behind earlier transforms.
   logic               pw1_ff;
   logic [3:0]         pi1_ff;
   logic signed [31:0] pd1_ff;
   logic               pw2_ff;
   logic [3:0]         pi2_ff;
   logic signed [31:0] pd2_ff;

   // Write one matrix element per load beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            view_ff[i] <= '0;
            proj_ff[i] <= '0;
         end
         pw1_ff <= 1'b0;
         pw2_ff <= 1'b0;
      end else if (advance) begin
         if (view_load) view_ff[in_req.element_index] <= in_req.element_value;
         if (pw2_ff) proj_ff[pi2_ff] <= pd2_ff;
         pw1_ff <= proj_load;
         pw2_ff <= pw1_ff;
      end
      if (advance) begin
         pi1_ff <= in_req.element_index;
         pd1_ff <= in_req.element_value;
         pi2_ff <= pi1_ff;
         pd2_ff <= pd1_ff;
      end
   end

   logic xform;
   assign xform = in_valid && in_req.kind != w2s_pkg::KIND_LOAD;

   // Stage 1: view products.
   logic               v1_ff;
   logic signed [63:0] vp1_ff [12];
   logic signed [31:0] vt1_ff [4];
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (advance) v1_ff <= xform;
      if (advance) begin
         for (int j = 0; j < 4; j++) begin
            vp1_ff[j]   <= 64'(in_req.point_x) * 64'(view_ff[j]);
            vp1_ff[4+j] <= 64'(in_req.point_y) * 64'(view_ff[4+j]);
            vp1_ff[8+j] <= 64'(in_req.point_z) * 64'(view_ff[8+j]);
            vt1_ff[j]   <= view_ff[12+j];
         end
      end
   end

   // Stage 2: sum, round half up, add translation, saturate.
   logic               v2_ff;
   logic signed [31:0] clip2_ff [4];
   always_ff @(posedge clock) begin
      logic signed [67:0] acc;
      if (reset) v2_ff <= 1'b0;
      else if (advance) v2_ff <= v1_ff;
      if (advance) begin
         for (int j = 0; j < 4; j++) begin
            acc = 68'(vp1_ff[j]) + 68'(vp1_ff[4+j]) + 68'(vp1_ff[8+j])
                  + (68'sd1 <<< (F - 1));
            clip2_ff[j] <= w2s_pkg::sat32(96'(acc >>> F) + 96'(vt1_ff[j]));
         end
      end
   end

   // Stage 3: projection products.
   logic               v3_ff;
   logic signed [63:0] pp3_ff [12];
   logic signed [31:0] w3_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (advance) v3_ff <= v2_ff;
      if (advance) begin
         for (int j = 0; j < 3; j++)
            for (int i = 0; i < 4; i++)
               pp3_ff[j*4+i] <= 64'(clip2_ff[i]) * 64'(proj_ff[i*4+j]);
         w3_ff <= clip2_ff[3];
      end
   end

   // Stage 4: sum and round the projected vector.
   logic               v4_ff;
   logic signed [31:0] p4_ff [3];
   logic signed [31:0] w4_ff;
   always_ff @(posedge clock) begin
      logic signed [67:0] acc;
      if (reset) v4_ff <= 1'b0;
      else if (advance) v4_ff <= v3_ff;
      if (advance) begin
         for (int j = 0; j < 3; j++) begin
            acc = 68'(pp3_ff[j*4]) + 68'(pp3_ff[j*4+1]) + 68'(pp3_ff[j*4+2])
                  + 68'(pp3_ff[j*4+3]) + (68'sd1 <<< (F - 1));
            p4_ff[j] <= w2s_pkg::sat32(96'(acc >>> F));
         end
         w4_ff <= w3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_p     = p4_ff;
   assign out_w     = w4_ff;
endmodule

/* hdl/world_to_screen_projection.sv */
// Top level of the vertex projection unit.
// Vertex projection unit: load beats write one element of the view or projection
// matrix; transform beats give one result each, in order. One beat is taken per
// cycle while the output is not stalled. A transform passes two multiply and two
// sum stages, three dividers for x, y and depth working side by side (input
// register, one quotient bit per stage for 32+FRAC_BITS bits, one hold stage),
// then the depth test with viewport products and the output register. Projection
// loads take effect two stages late so that every transform sees exactly the
// loads sent before it. Stalls on the result side freeze the whole pipeline; a
// skid-free output register holds the result.
module world_to_screen_projection (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  w2s_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output w2s_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   logic [13:0] width_ff;
   logic [13:0] height_ff;

   // Register file.
   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= w2s_pkg::WIDTH_RESET;
         height_ff <= w2s_pkg::HEIGHT_RESET;
      end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
         if (paddr[2] == w2s_pkg::ADDR_WIDTH) width_ff <= pwdata[13:0];
         else height_ff <= pwdata[13:0];
      end
   end
   always_comb begin
      prdata = '0;
      if (paddr[1:0] == 2'b00) begin
         if (paddr[2] == w2s_pkg::ADDR_WIDTH) prdata = {18'd0, width_ff};
         else prdata = {18'd0, height_ff};
      end
   end

   // Whole pipeline advances when the output register is free or drains.
   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   logic               t_valid;
   logic signed [31:0] t_p [3];
   logic signed [31:0] t_w;
   w2s_transform u_xf (
      .clock, .reset, .advance,
      .in_valid (req_valid),
      .in_req   (req_data),
      .out_valid(t_valid),
      .out_p    (t_p),
      .out_w    (t_w)
   );

   // Three dividers by clip w; the tag carries the zero-w flag.
   logic               d_valid [3];
   logic signed [31:0] d_q [3];
   logic [2:0]         d_tag [3];
   genvar k;
   generate
      for (k = 0; k < 3; k++) begin : g_div
         w2s_divider u_div (
            .clock, .reset, .advance,
            .in_valid (t_valid),
            .in_num   (t_p[k]),
            .in_den   (t_w),
            .in_tag   ({2'b00, t_w == 32'sd0}),
            .out_valid(d_valid[k]),
            .out_quot (d_q[k]),
            .out_tag  (d_tag[k])
         );
      end
   endgenerate

   // Depth test and viewport products.
   logic               s1_v_ff;
   logic               s1_vis_ff;
   logic signed [47:0] s1_sx_ff;
   logic signed [47:0] s1_sy_ff;
   always_ff @(posedge clock) begin
      logic signed [33:0] ox;
      logic signed [33:0] oy;
      if (reset) s1_v_ff <= 1'b0;
      else if (advance) s1_v_ff <= d_valid[0];
      if (advance) begin
         ox = 34'(d_q[0]) + 34'(w2s_pkg::ONE_Q);
         oy = 34'(w2s_pkg::ONE_Q) - 34'(d_q[1]);
         s1_vis_ff <= !d_tag[2][0] && d_valid[1] && d_valid[2]
                      && d_q[2] >= 32'(w2s_pkg::DEPTH_MIN)
                      && d_q[2] <= 32'(w2s_pkg::ONE_Q);
         s1_sx_ff <= 48'($signed({1'b0, width_ff})) * 48'(ox);
         s1_sy_ff <= 48'($signed({1'b0, height_ff})) * 48'(oy);
      end
   end

   // Output register: halve with floor and saturate.
   logic             out_v_ff;
   w2s_pkg::rsp_type out_ff;
   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (advance) out_v_ff <= s1_v_ff;
      if (advance) begin
         out_ff.visible  <= s1_vis_ff;
         out_ff.screen_x <= s1_vis_ff ? w2s_pkg::sat32(96'(s1_sx_ff >>> 1)) : '0;
         out_ff.screen_y <= s1_vis_ff ? w2s_pkg::sat32(96'(s1_sy_ff >>> 1)) : '0;
      end
   end
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;
endmodule

/* hdl/w2s_checker.sv */
// Port-level checker for the projection unit, bound to the top level.
`include "assert_macros.svh"
module w2s_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input w2s_pkg::rsp_type rsp_data,
   input logic             pready
);
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result dropped while stalled")
   `CHK_IMPLY(a_ready_free, clock, reset, !rsp_valid, req_ready, "input blocked with empty output")
   `CHK_IMPLY(a_hidden_zero, clock, reset, rsp_valid && !rsp_data.visible, rsp_data.screen_x == 32'sd0 && rsp_data.screen_y == 32'sd0, "hidden point has coordinates")
   `CHK_IMPLY(a_pready, clock, reset, 1'b1, pready, "pready low")
endmodule

bind world_to_screen_projection w2s_checker u_chk (.*);
